FILE: src/tbu_pkg.sv
// Shared types, widths and codes for the tracker box update block.
// No dependencies; every other file of the block imports it.
package tbu_pkg;

	localparam int COORD_BITS = 13;
	localparam int LB_W       = (COORD_BITS + 1 > 14) ? COORD_BITS + 1 : 14;
	localparam int W_W        = LB_W - 1;
	localparam int FRAME_W    = 13;
	localparam int PRED_W     = 18;
	localparam int SCORE_W    = 16;
	localparam int FACTOR_W   = 12;
	localparam int MARGIN_W   = 8;
	localparam int PHASE_W    = 16;
	localparam int BEST_W     = 18;
	localparam int CFG_W      = 16;
	localparam int CFG_IDX_W  = 3;

	localparam int MA_W = 2 * W_W + 1;
	localparam int MB_W = 2 * FACTOR_W + 1;
	localparam int P_W  = MA_W + MB_W;
	localparam int N_W  = 2 * W_W + 2 * FACTOR_W;
	localparam int R_W  = N_W / 2;
	localparam int C_W  = R_W - 7;
	localparam int K_W  = C_W + 3;
	localparam int E_W  = C_W + 22;
	localparam int SQ_CNT_W = $clog2(R_W);

	localparam int OFF_PRED  = 4 * COORD_BITS;
	localparam int OFF_SCORE = OFF_PRED + 4 * PRED_W;
	localparam int OFF_FW    = OFF_SCORE + SCORE_W;
	localparam int OFF_FH    = OFF_FW + FRAME_W;
	localparam int IN_BITS   = OFF_FH + FRAME_W;
	localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS  = 4 * COORD_BITS + SCORE_W;
	localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;
	localparam int OUT_USER_W = 3;

	localparam logic signed [BEST_W-1:0] BEST_RESET = -(BEST_W'(65536));

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SEARCH_SIZE      = 3'd0,
		CFG_SEARCH_FACTOR    = 3'd1,
		CFG_SCORE_FLOOR      = 3'd2,
		CFG_CAPTURE_SCORE    = 3'd3,
		CFG_SCORE_DECAY      = 3'd4,
		CFG_EDGE_MARGIN      = 3'd5,
		CFG_REFRESH_INTERVAL = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic           done;
		logic [R_W-1:0] root;
		logic           inexact;
	} sqrt_res_t;

endpackage

FILE: src/tbu_mul.sv
// Shared signed multiplier with a registered product.
// Depends on tbu_pkg for operand widths.
module tbu_mul import tbu_pkg::*; (
	input  logic                   clk,
	input  logic signed [MA_W-1:0] a,
	input  logic signed [MB_W-1:0] b,
	output logic signed [P_W-1:0]  p
);

	logic signed [P_W-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

	assign p = p_q;

endmodule

FILE: src/tbu_sqrt.sv
// Digit-by-digit integer square root, one root bit per cycle.
// Depends on tbu_pkg for widths and the result struct.
module tbu_sqrt import tbu_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [N_W-1:0] radicand,
	output sqrt_res_t      res
);

	logic                busy_q;
	logic                done_q;
	logic [SQ_CNT_W-1:0] cnt_q;
	logic [N_W-1:0]      n_q;
	logic [R_W:0]        rem_q;
	logic [R_W-1:0]      root_q;
	logic [R_W+2:0]      trial;
	logic [R_W+2:0]      test;
	logic [R_W+2:0]      diff;
	logic                last;

	assign trial = {rem_q, n_q[N_W-1 -: 2]};
	assign test  = {1'b0, root_q, 2'b01};
	assign diff  = trial - test;
	assign last  = (cnt_q == SQ_CNT_W'(R_W - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && last;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && last) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q    <= radicand;
			rem_q  <= '0;
			root_q <= '0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			n_q   <= n_q << 2;
			cnt_q <= cnt_q + 1'b1;
			if (trial >= test) begin
				rem_q  <= diff[R_W:0];
				root_q <= {root_q[R_W-2:0], 1'b1};
			end else begin
				rem_q  <= trial[R_W:0];
				root_q <= {root_q[R_W-2:0], 1'b0};
			end
		end
	end

	assign res.done    = done_q;
	assign res.root    = root_q;
	assign res.inexact = |rem_q;

endmodule

FILE: src/tracker_box_update_top.sv
// Top level of the tracker box update block: sequencer, state and datapath.
// Depends on tbu_pkg, tbu_mul and tbu_sqrt.
//
// Input stream s_axis: one transfer is one item. tuser is the operation
// (0 loads the initial box, 1 tracks one frame). An init item is taken while
// idle and gives no result. A track item gives exactly one result on
// m_axis; tuser[0] says whether a box was found, otherwise the result is
// all zero.
// A track item runs from its transfer to the loading of the result
// register through three steps on the shared multiplier for the crop
// area, the start of the square root, the square root unit, the crop
// check, four box products, the score decay and the final step. An
// item that fails the crop or prediction check goes from the crop check
// to the final step, one whose stored box is invalid straight from its
// transfer to the final step.
// s_axis_tready is high only while the sequencer is idle, so the input
// is held off until a track item has left the final step.
// The result sits in an output register; the sequencer accepts the next
// item while it waits and stalls only when a second result is ready
// before the first has been taken.
// Reset clears the stored box and frame phase, sets best_q to BEST_RESET
// and loads register defaults. Configuration is written through cfg_wen.
module tracker_box_update_top import tbu_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wen,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_wdata,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// start_x0, start_y0, start_x1, start_y1, pred_cx, pred_cy, pred_w, pred_h,
	// score, frame_width, frame_height
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// operation
	input  logic                  s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// box_x0, box_y0, box_x1, box_y1, box_score
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	// found, capture_template, refresh_template
	output logic [OUT_USER_W-1:0] m_axis_tuser
);

	typedef enum logic [12:0] {
		S_IDLE = 13'b0000000000001,
		S_WH   = 13'b0000000000010,
		S_S2   = 13'b0000000000100,
		S_N    = 13'b0000000001000,
		S_SQS  = 13'b0000000010000,
		S_SQRT = 13'b0000000100000,
		S_CROP = 13'b0000001000000,
		S_CX   = 13'b0000010000000,
		S_CY   = 13'b0000100000000,
		S_PW   = 13'b0001000000000,
		S_PH   = 13'b0010000000000,
		S_DEC  = 13'b0100000000000,
		S_FIN  = 13'b1000000000000
	} state_t;

	state_t state_q;

	logic [FACTOR_W-1:0] factor_q;
	logic [SCORE_W-1:0]  floor_q;
	logic [SCORE_W-1:0]  capture_q;
	logic [SCORE_W-1:0]  decay_q;
	logic [MARGIN_W-1:0] margin_q;
	logic [PHASE_W-1:0]  interval_q;

	logic signed [LB_W-1:0]   last_box_q [4];
	logic [PHASE_W-1:0]       phase_q;
	logic signed [BEST_W-1:0] best_q;

	logic signed [PRED_W-1:0] pcx_q, pcy_q, pw_q, ph_q;
	logic [SCORE_W-1:0]       score_q;
	logic [FRAME_W-1:0]       fw_q, fh_q;

	logic [2*W_W-1:0]        wh_q;
	logic [C_W-1:0]          c_q;
	logic signed [E_W-1:0]   cxp_q, cyp_q, wp_q, hp_q;
	logic                    found_q, cap_q, refresh_q;
	logic signed [LB_W-1:0]  res_box_q [4];
	logic signed [BEST_W-1:0] new_best_q;

	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic [OUT_USER_W-1:0] out_user_q;

	logic signed [COORD_BITS-1:0] in_box [4];
	logic signed [MA_W-1:0] mul_a;
	logic signed [MB_W-1:0] mul_b;
	logic signed [P_W-1:0]  mul_p;
	sqrt_res_t              sq_res;
	logic                   sq_start;

	logic                   box_bad;
	logic signed [LB_W-1:0] w_s, h_s;
	logic [PHASE_W:0]       phase_inc;
	logic [PHASE_W-1:0]     phase_next;
	logic [R_W:0]           c_sum;
	logic signed [K_W-1:0]  vx, vy;
	logic                   pred_bad;
	logic signed [BEST_W-1:0] dec_best;
	logic signed [BEST_W-1:0] score_ext;
	logic                   cap_now;
	logic signed [E_W-1:0]  e0, e1, e2, e3;
	logic                   in_xfer;
	logic                   fin_go;

	function automatic logic crop_ok(logic signed [K_W-1:0] v, logic [C_W-1:0] c,
			logic [FRAME_W-1:0] size);
		logic signed [K_W-1:0] lo, hi, lim, mn, mx;
		lo  = (v >>> 1) + $signed(K_W'({1'b0, v[0] & ~v[K_W-1]}));
		hi  = lo + K_W'($signed({1'b0, c}));
		lim = K_W'($signed({1'b0, size})) - K_W'(1);
		mn  = (hi < lim) ? hi : lim;
		mx  = (lo > 0) ? lo : '0;
		return mn > mx;
	endfunction

	function automatic logic signed [E_W-1:0] box_edge(logic signed [E_W-1:0] cp,
			logic signed [E_W-1:0] hp, logic signed [K_W-1:0] v, logic plus);
		logic signed [E_W-1:0] ctr;
		logic signed [E_W-1:0] sum;
		ctr = (cp <<< 1) + (E_W'(v) <<< 16);
		sum = plus ? ctr + hp : ctr - hp;
		return sum >>> 17;
	endfunction

	function automatic logic signed [LB_W-1:0] clip_lo(logic signed [E_W-1:0] v,
			logic [FRAME_W-1:0] size, logic [MARGIN_W-1:0] m);
		logic signed [E_W-1:0] lim, t;
		lim = E_W'($signed({1'b0, size})) - E_W'($signed({1'b0, m}));
		if (lim < 0)
			lim = '0;
		t = (v < 0) ? '0 : v;
		if (t > lim)
			t = lim;
		return t[LB_W-1:0];
	endfunction

	function automatic logic signed [LB_W-1:0] clip_hi(logic signed [E_W-1:0] v,
			logic [FRAME_W-1:0] size, logic [MARGIN_W-1:0] m);
		logic signed [E_W-1:0] sz, mg, t;
		sz = E_W'($signed({1'b0, size}));
		mg = E_W'($signed({1'b0, m}));
		t  = (v < mg) ? mg : v;
		if (t > sz)
			t = sz;
		return t[LB_W-1:0];
	endfunction

	always_comb begin
		for (int i = 0; i < 4; i++)
			in_box[i] = s_axis_tdata[i*COORD_BITS +: COORD_BITS];
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign fin_go        = !out_valid_q || m_axis_tready;

	assign box_bad = last_box_q[0] < 0 || last_box_q[1] < 0 ||
		last_box_q[2] <= last_box_q[0] || last_box_q[3] <= last_box_q[1];
	assign w_s = last_box_q[2] - last_box_q[0];
	assign h_s = last_box_q[3] - last_box_q[1];

	assign phase_inc  = {1'b0, phase_q} + (PHASE_W+1)'(1);
	assign phase_next = (phase_inc >= {1'b0, interval_q}) ? '0 : phase_inc[PHASE_W-1:0];

	assign c_sum = {1'b0, sq_res.root} + (R_W+1)'(sq_res.inexact) + (R_W+1)'(255);

	assign vx = K_W'(last_box_q[0]) + K_W'(last_box_q[2]) - K_W'($signed({1'b0, c_q}));
	assign vy = K_W'(last_box_q[1]) + K_W'(last_box_q[3]) - K_W'($signed({1'b0, c_q}));

	assign pred_bad = pcx_q < 0 || pcy_q < 0 || pw_q <= 0 || ph_q <= 0 || score_q < floor_q;

	assign dec_best  = mul_p[16 +: BEST_W];
	assign score_ext = $signed({2'b00, score_q});
	assign cap_now   = score_q > capture_q && score_ext > dec_best;

	assign e0 = box_edge(cxp_q, wp_q, vx, 1'b0);
	assign e1 = box_edge(cyp_q, hp_q, vy, 1'b0);
	assign e2 = box_edge(cxp_q, wp_q, vx, 1'b1);
	assign e3 = box_edge(cyp_q, hp_q, vy, 1'b1);

	assign sq_start = (state_q == S_SQS);

	always_comb begin
		mul_a = '0;
		mul_b = MB_W'($signed({1'b0, c_q}));
		unique case (state_q)
			S_WH: begin
				mul_a = MA_W'($signed({1'b0, w_s[W_W-1:0]}));
				mul_b = MB_W'($signed({1'b0, h_s[W_W-1:0]}));
			end
			S_S2: begin
				mul_a = MA_W'($signed({1'b0, factor_q}));
				mul_b = MB_W'($signed({1'b0, factor_q}));
			end
			S_N: begin
				mul_a = $signed({1'b0, wh_q});
				mul_b = $signed({1'b0, mul_p[2*FACTOR_W-1:0]});
			end
			S_CROP: mul_a = MA_W'(pcx_q);
			S_CX:   mul_a = MA_W'(pcy_q);
			S_CY:   mul_a = MA_W'(pw_q);
			S_PW:   mul_a = MA_W'(ph_q);
			S_PH: begin
				mul_a = MA_W'(best_q);
				mul_b = MB_W'($signed({1'b0, decay_q}));
			end
			default: mul_a = '0;
		endcase
	end

	tbu_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	tbu_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (mul_p[N_W-1:0]),
		.res      (sq_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			factor_q    <= FACTOR_W'(1024);
			floor_q     <= SCORE_W'(6554);
			capture_q   <= SCORE_W'(58982);
			decay_q     <= SCORE_W'(65535);
			margin_q    <= MARGIN_W'(10);
			interval_q  <= PHASE_W'(200);
			for (int i = 0; i < 4; i++)
				last_box_q[i] <= '0;
			phase_q     <= '0;
			best_q      <= BEST_RESET;
			out_valid_q <= 1'b0;
			found_q     <= 1'b0;
		end else begin
			if (cfg_wen) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_SEARCH_FACTOR:    factor_q   <= cfg_wdata[FACTOR_W-1:0];
					CFG_SCORE_FLOOR:      floor_q    <= cfg_wdata[SCORE_W-1:0];
					CFG_CAPTURE_SCORE:    capture_q  <= cfg_wdata[SCORE_W-1:0];
					CFG_SCORE_DECAY:      decay_q    <= cfg_wdata[SCORE_W-1:0];
					CFG_EDGE_MARGIN:      margin_q   <= cfg_wdata[MARGIN_W-1:0];
					CFG_REFRESH_INTERVAL: interval_q <= cfg_wdata[PHASE_W-1:0];
					default: ;
				endcase
			end

			if (state_q == S_FIN && fin_go)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						if (!s_axis_tuser) begin
							for (int i = 0; i < 4; i++)
								last_box_q[i] <= LB_W'(in_box[i]);
						end else begin
							phase_q <= phase_next;
							found_q <= 1'b0;
							state_q <= box_bad ? S_FIN : S_WH;
						end
					end
				end
				S_WH:   state_q <= S_S2;
				S_S2:   state_q <= S_N;
				S_N:    state_q <= S_SQS;
				S_SQS:  state_q <= S_SQRT;
				S_SQRT: begin
					if (sq_res.done)
						state_q <= S_CROP;
				end
				S_CROP: begin
					if (!crop_ok(vx, c_q, fw_q) || !crop_ok(vy, c_q, fh_q) || pred_bad)
						state_q <= S_FIN;
					else
						state_q <= S_CX;
				end
				S_CX:  state_q <= S_CY;
				S_CY:  state_q <= S_PW;
				S_PW:  state_q <= S_PH;
				S_PH:  state_q <= S_DEC;
				S_DEC: begin
					found_q <= 1'b1;
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (fin_go) begin
						if (found_q) begin
							for (int i = 0; i < 4; i++)
								last_box_q[i] <= res_box_q[i];
							best_q <= new_best_q;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer && s_axis_tuser) begin
			pcx_q     <= s_axis_tdata[OFF_PRED +: PRED_W];
			pcy_q     <= s_axis_tdata[OFF_PRED + PRED_W +: PRED_W];
			pw_q      <= s_axis_tdata[OFF_PRED + 2*PRED_W +: PRED_W];
			ph_q      <= s_axis_tdata[OFF_PRED + 3*PRED_W +: PRED_W];
			score_q   <= s_axis_tdata[OFF_SCORE +: SCORE_W];
			fw_q      <= s_axis_tdata[OFF_FW +: FRAME_W];
			fh_q      <= s_axis_tdata[OFF_FH +: FRAME_W];
			refresh_q <= (phase_next == '0);
		end
		if (state_q == S_S2)
			wh_q <= mul_p[2*W_W-1:0];
		if (state_q == S_SQRT && sq_res.done)
			c_q <= c_sum[R_W:8];
		if (state_q == S_CX)
			cxp_q <= mul_p[E_W-1:0];
		if (state_q == S_CY)
			cyp_q <= mul_p[E_W-1:0];
		if (state_q == S_PW)
			wp_q <= mul_p[E_W-1:0];
		if (state_q == S_PH)
			hp_q <= mul_p[E_W-1:0];
		if (state_q == S_DEC) begin
			res_box_q[0] <= clip_lo(e0, fw_q, margin_q);
			res_box_q[1] <= clip_lo(e1, fh_q, margin_q);
			res_box_q[2] <= clip_hi(e2, fw_q, margin_q);
			res_box_q[3] <= clip_hi(e3, fh_q, margin_q);
			cap_q        <= cap_now;
			if (refresh_q)
				new_best_q <= BEST_RESET;
			else
				new_best_q <= cap_now ? score_ext : dec_best;
		end
		if (state_q == S_FIN && fin_go) begin
			if (found_q) begin
				out_data_q <= OUT_DATA_W'({score_q,
					res_box_q[3][COORD_BITS-1:0], res_box_q[2][COORD_BITS-1:0],
					res_box_q[1][COORD_BITS-1:0], res_box_q[0][COORD_BITS-1:0]});
				out_user_q <= {refresh_q, cap_q, 1'b1};
			end else begin
				out_data_q <= '0;
				out_user_q <= '0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

endmodule

FILE: src/tbu_chk.sv
// Port-level checker for the tracker box update block, bound to the top level.
// Depends on tbu_pkg for port widths.
module tbu_chk import tbu_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_axis_tvalid,
	input logic                  s_axis_tready,
	input logic                  s_axis_tuser,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [OUT_DATA_W-1:0] m_axis_tdata,
	input logic [OUT_USER_W-1:0] m_axis_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result changed while stalled");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0 && m_axis_tuser == '0)
		else $error("empty result not zero");

	a_refresh_found: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tuser[0])
		else $error("refresh on empty result");

	a_track_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser |=> !s_axis_tready)
		else $error("ready after track transfer");

endmodule

bind tracker_box_update_top tbu_chk u_tbu_chk (.*);
